[rtl/sbnh_pkg.sv]
package sbnh_pkg;

  localparam int SLOTS = 32;
  localparam int FRAC_BITS = 8;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SLOT_IN_W = 5;
  localparam int COORD_W = 24;
  localparam int VAL_W = 27;
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_W = 17;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam int HW_RAW = ((4 << FRAC_BITS) + 5) / 10;
  localparam int HT_RAW = ((18 << FRAC_BITS) + 5) / 10;
  localparam int HW_RESET = (HW_RAW > 65535) ? 65535 : HW_RAW;
  localparam int HT_RESET = (HT_RAW > 65535) ? 65535 : HT_RAW;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = CFG_IDX_W'(1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

[rtl/sbnh_mul.sv]
module sbnh_mul (
  input  logic           clk,
  input  sbnh_pkg::val_t op_a,
  input  sbnh_pkg::val_t op_b,
  output sbnh_pkg::prod_t prod_r
);
  import sbnh_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[rtl/sbnh_div.sv]
module sbnh_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          div_start,
  input  logic [sbnh_pkg::VAL_W-1:0]    num,
  input  logic [sbnh_pkg::VAL_W-1:0]    den,
  output logic                          done_r,
  output logic [sbnh_pkg::FRAC_W-1:0]   quot_r
);
  import sbnh_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W);

  logic [VAL_W:0]   rem_r;
  logic [VAL_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             ge;
  logic [VAL_W:0]   diff;

  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= {1'b0, num};
        den_r <= den;
      end else if (run_r) begin
        rem_r  <= {diff[VAL_W-1:0], 1'b0};
        quot_r <= {quot_r[FRAC_W-2:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/segment_box_nearest_hit_top.sv]
// segment versus box table, nearest hit along a segment
// input channel: an item is taken when start is high and busy is low.
//   in_cmd write loads one slot (position and alive flag) and busy stays
//   low. in_cmd query starts a scan and raises busy.
// result channel: one item per query, shown for one cycle with out_valid.
//   the receiver cannot stall; the result is simply there for that cycle.
// config channel: cfg_ready is always high, a write lands when cfg_valid is
//   high. index 0 is half_width, index 1 is box_height.
// a query scans every slot in turn; each live non-owner slot takes up to 10
//   slab compares (enter, exit and cross on each axis, then a best compare),
//   and a hit ends with a final divide. all compares share the one 27x27
//   multiplier: every slab compare is a cross product pair, and the restoring
//   divider makes one quotient bit per cycle.
// reset: all slots dead, config registers at their defaults, block idle.
module segment_box_nearest_hit_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [sbnh_pkg::SLOT_IN_W-1:0]    in_slot,
  input  logic                              in_alive,
  input  sbnh_pkg::coord_t                  in_point_x,
  input  sbnh_pkg::coord_t                  in_point_y,
  input  sbnh_pkg::coord_t                  in_point_z,
  input  sbnh_pkg::coord_t                  in_end_x,
  input  sbnh_pkg::coord_t                  in_end_y,
  input  sbnh_pkg::coord_t                  in_end_z,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [sbnh_pkg::SLOT_IN_W-1:0]    out_hit_slot,
  output logic [sbnh_pkg::FRAC_W-1:0]       out_entry_fraction,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbnh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbnh_pkg::CFG_W-1:0]        cfg_data
);
  import sbnh_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_LD, S_CMP, S_FIN, S_DIVW} state_t;
  typedef enum logic [1:0] {OP_ENTER, OP_EXIT, OP_CROSS, OP_BEST} op_t;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD = 2'd2;

  state_t               state_r;
  op_t                  op_r;
  logic [1:0]           ph_r;
  logic [1:0]           ax_r;
  logic [SLOT_W-1:0]    idx_r;
  logic [SLOT_IN_W-1:0] owner_r;
  coord_t               p_r [3];
  coord_t               e_r [3];
  logic [CFG_W-1:0]     hw_r;
  logic [CFG_W-1:0]     ht_r;
  logic [SLOTS-1:0]     alive_r;
  logic [2*COORD_W-1:0] xz_mem [SLOTS];
  coord_t               y_mem [SLOTS];
  logic [2*COORD_W-1:0] rd_xz_r;
  coord_t               rd_y_r;
  val_t                 a_r, b_r, d_r, n0_r, d0_r, n1_r, d1_r, bn_r, bd_r;
  logic [SLOT_W-1:0]    bslot_r;
  logic                 found_r;
  prod_t                p1_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [SLOT_IN_W-1:0] out_slot_r;
  logic [FRAC_W-1:0]    out_frac_r;

  logic              in_acc;
  logic              wr_ok;
  logic [SLOT_W-1:0] wr_idx;
  logic              last;
  logic              own_hit;
  coord_t            pos_v, f_v, e_v;
  logic [CFG_W-1:0]  lo_sub, hi_add;
  val_t              lo_v, hi_v, a_v, b_v, dd_v, a_f, b_f, d_f;
  logic              dzero, outside;
  val_t              m1a, m1b, m2a, m2b, mul_a, mul_b;
  prod_t             prod_r;
  logic              gt, lt;
  logic              div_start, div_done;
  logic [FRAC_W-1:0] div_quot;

  assign in_acc  = start && !busy;
  assign wr_ok   = int'(in_slot) < SLOTS;
  assign wr_idx  = SLOT_W'(in_slot);
  assign last    = idx_r == SLOT_W'(SLOTS - 1);
  assign own_hit = int'(idx_r) == int'(owner_r);
  assign busy    = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  // box bounds and slab terms for the current axis
  always_comb begin
    unique case (ax_r)
      AX_Y: begin
        pos_v = rd_y_r;
        lo_sub = '0;
        hi_add = ht_r;
      end
      AX_Z: begin
        pos_v = rd_xz_r[COORD_W-1:0];
        lo_sub = hw_r;
        hi_add = hw_r;
      end
      default: begin
        pos_v = rd_xz_r[2*COORD_W-1:COORD_W];
        lo_sub = hw_r;
        hi_add = hw_r;
      end
    endcase
    f_v = p_r[ax_r];
    e_v = e_r[ax_r];
    lo_v = val_t'(pos_v) - val_t'({1'b0, lo_sub});
    hi_v = val_t'(pos_v) + val_t'({1'b0, hi_add});
    a_v  = lo_v - val_t'(f_v);
    b_v  = hi_v - val_t'(f_v);
    dd_v = val_t'(e_v) - val_t'(f_v);
    dzero = dd_v == '0;
    outside = (a_v > 0) || (b_v < 0);
    a_f = (dd_v < 0) ? -b_v : a_v;
    b_f = (dd_v < 0) ? -a_v : b_v;
    d_f = (dd_v < 0) ? -dd_v : dd_v;
  end

  always_comb begin
    unique case (op_r)
      OP_ENTER: begin m1a = a_r;  m1b = d0_r; m2a = n0_r; m2b = d_r;  end
      OP_EXIT:  begin m1a = b_r;  m1b = d1_r; m2a = n1_r; m2b = d_r;  end
      OP_CROSS: begin m1a = n0_r; m1b = d1_r; m2a = n1_r; m2b = d0_r; end
      default:  begin m1a = n0_r; m1b = bd_r; m2a = bn_r; m2b = d0_r; end
    endcase
    mul_a = (ph_r == PH_FIRST) ? m1a : m2a;
    mul_b = (ph_r == PH_FIRST) ? m1b : m2b;
  end

  assign gt = p1_r > prod_r;
  assign lt = p1_r < prod_r;
  assign div_start = (state_r == S_FIN) && found_r;

  sbnh_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  sbnh_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .num       (bn_r),
    .den       (bd_r),
    .done_r    (div_done),
    .quot_r    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_WRITE && wr_ok) begin
      xz_mem[wr_idx] <= {in_point_x, in_point_z};
      y_mem[wr_idx] <= in_point_y;
    end
    rd_xz_r <= xz_mem[idx_r];
    rd_y_r <= y_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      alive_r <= '0;
      hw_r <= CFG_W'(HW_RESET);
      ht_r <= CFG_W'(HT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_HALF_WIDTH) hw_r <= cfg_data;
        else if (cfg_index == CFG_BOX_HEIGHT) ht_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          if (in_cmd == CMD_WRITE) begin
            if (wr_ok) alive_r[wr_idx] <= in_alive;
          end else begin
            p_r[0] <= in_point_x;
            p_r[1] <= in_point_y;
            p_r[2] <= in_point_z;
            e_r[0] <= in_end_x;
            e_r[1] <= in_end_y;
            e_r[2] <= in_end_z;
            owner_r <= in_slot;
            idx_r <= '0;
            found_r <= 1'b0;
            bn_r <= '0;
            bd_r <= val_t'(1);
            bslot_r <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (alive_r[idx_r] && !own_hit) begin
            ax_r <= AX_X;
            n0_r <= '0;
            d0_r <= val_t'(1);
            n1_r <= val_t'(1);
            d1_r <= val_t'(1);
            state_r <= S_LD;
          end else if (last) begin
            state_r <= S_FIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_LD: begin
          if (dzero) begin
            if (outside) begin
              if (last) state_r <= S_FIN;
              else begin
                idx_r <= idx_r + 1'b1;
                state_r <= S_RD;
              end
            end else if (ax_r == AX_Z) begin
              op_r <= OP_BEST;
              ph_r <= PH_FIRST;
              state_r <= S_CMP;
            end else begin
              ax_r <= ax_r + 1'b1;
            end
          end else begin
            a_r <= a_f;
            b_r <= b_f;
            d_r <= d_f;
            op_r <= OP_ENTER;
            ph_r <= PH_FIRST;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          unique case (ph_r)
            PH_FIRST: ph_r <= PH_SECOND;
            PH_SECOND: begin
              p1_r <= prod_r;
              ph_r <= PH_THIRD;
            end
            default: begin
              ph_r <= PH_FIRST;
              unique case (op_r)
                OP_ENTER: begin
                  if (gt) begin
                    n0_r <= a_r;
                    d0_r <= d_r;
                  end
                  op_r <= OP_EXIT;
                end
                OP_EXIT: begin
                  if (lt) begin
                    n1_r <= b_r;
                    d1_r <= d_r;
                  end
                  op_r <= OP_CROSS;
                end
                OP_CROSS: begin
                  if (gt) begin
                    if (last) state_r <= S_FIN;
                    else begin
                      idx_r <= idx_r + 1'b1;
                      state_r <= S_RD;
                    end
                  end else if (ax_r == AX_Z) begin
                    op_r <= OP_BEST;
                  end else begin
                    ax_r <= ax_r + 1'b1;
                    state_r <= S_LD;
                  end
                end
                default: begin
                  if (!found_r || lt) begin
                    found_r <= 1'b1;
                    bn_r <= n0_r;
                    bd_r <= d0_r;
                    bslot_r <= idx_r;
                  end
                  if (last) state_r <= S_FIN;
                  else begin
                    idx_r <= idx_r + 1'b1;
                    state_r <= S_RD;
                  end
                end
              endcase
            end
          endcase
        end
        S_FIN: begin
          if (found_r) begin
            state_r <= S_DIVW;
          end else begin
            out_valid_r <= 1'b1;
            out_hit_r <= 1'b0;
            out_slot_r <= '0;
            out_frac_r <= '0;
            state_r <= S_IDLE;
          end
        end
        S_DIVW: if (div_done) begin
          out_valid_r <= 1'b1;
          out_hit_r <= 1'b1;
          out_slot_r <= SLOT_IN_W'(bslot_r);
          out_frac_r <= div_quot;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit = out_hit_r;
  assign out_hit_slot = out_slot_r;
  assign out_entry_fraction = out_frac_r;

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_FIN || $past(state_r) == S_DIVW))
    else $error("result without finished scan");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_slot == '0 && out_entry_fraction == '0)
    else $error("miss result not cleared");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_entry_fraction <= FRAC_ONE)
    else $error("entry fraction above one");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> d0_r > 0 && d1_r > 0 && bd_r > 0)
    else $error("slab denominator not positive");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_QUERY |=> busy)
    else $error("query item did not start a scan");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sbnh_pkg::*;

  localparam int LIMIT_CYCLES = 8_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(3);

  typedef struct {
    logic hit;
    logic [SLOT_IN_W-1:0] slot;
    logic [FRAC_W-1:0] frac;
  } hit_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_cmd;
  logic [SLOT_IN_W-1:0] in_slot;
  logic in_alive;
  coord_t in_point_x, in_point_y, in_point_z;
  coord_t in_end_x, in_end_y, in_end_z;
  logic out_valid;
  logic out_hit;
  logic [SLOT_IN_W-1:0] out_hit_slot;
  logic [FRAC_W-1:0] out_entry_fraction;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // predictor state
  coord_t slot_px[SLOTS];
  coord_t slot_py[SLOTS];
  coord_t slot_pz[SLOTS];
  bit slot_live[SLOTS];
  logic [CFG_W-1:0] half_w;
  logic [CFG_W-1:0] height;

  hit_t expected_hits[$];
  hit_t want;
  int idle_pct;
  int errors;
  int cycles;
  int items_sent;
  int queries_sent;
  int hits_seen;
  int results_seen;

  segment_box_nearest_hit_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_slot(in_slot), .in_alive(in_alive),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .out_valid(out_valid), .out_hit(out_hit), .out_hit_slot(out_hit_slot),
    .out_entry_fraction(out_entry_fraction),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // clip segment against one box, entry t = en / ed
  function automatic bit clip_box(input longint f[3], input longint e[3],
                                  input longint lo[3], input longint hi[3],
                                  output longint en, output longint ed);
    longint n0, d0, n1, d1, d, a, b, tmp;
    n0 = 0; d0 = 1; n1 = 1; d1 = 1;
    en = 0; ed = 1;
    for (int ax = 0; ax < 3; ax++) begin
      d = e[ax] - f[ax];
      if (d == 0) begin
        if (f[ax] < lo[ax] || f[ax] > hi[ax]) return 0;
        continue;
      end
      a = lo[ax] - f[ax];
      b = hi[ax] - f[ax];
      if (d < 0) begin
        tmp = -a;
        a = -b;
        b = tmp;
        d = -d;
      end
      if (a * d0 > n0 * d) begin
        n0 = a; d0 = d;
      end
      if (b * d1 < n1 * d) begin
        n1 = b; d1 = d;
      end
      if (n0 * d1 > n1 * d0) return 0;
    end
    en = n0;
    ed = d0;
    return 1;
  endfunction

  function automatic hit_t nearest_hit(input logic [SLOT_IN_W-1:0] owner,
                                       input coord_t px, py, pz, ex, ey, ez);
    longint f[3], e[3], lo[3], hi[3];
    longint n, d, bn, bd;
    bit found;
    hit_t r;
    f[0] = px; f[1] = py; f[2] = pz;
    e[0] = ex; e[1] = ey; e[2] = ez;
    found = 0; bn = 0; bd = 1;
    r.hit = 1'b0; r.slot = '0; r.frac = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_live[i] || i == owner) continue;
      lo[0] = longint'(slot_px[i]) - longint'(half_w);
      hi[0] = longint'(slot_px[i]) + longint'(half_w);
      lo[1] = longint'(slot_py[i]);
      hi[1] = longint'(slot_py[i]) + longint'(height);
      lo[2] = longint'(slot_pz[i]) - longint'(half_w);
      hi[2] = longint'(slot_pz[i]) + longint'(half_w);
      if (clip_box(f, e, lo, hi, n, d)) begin
        if (!found || n * bd < bn * d) begin
          found = 1; bn = n; bd = d;
          r.slot = SLOT_IN_W'(i);
        end
      end
    end
    if (found) begin
      r.hit = 1'b1;
      r.frac = FRAC_W'((bn << 16) / bd);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        report("result with no query pending");
      end else begin
        want = expected_hits[0];
        expected_hits.delete(0);
        if (out_hit !== want.hit)
          report($sformatf("hit got %0b want %0b", out_hit, want.hit));
        if (out_hit_slot !== want.slot)
          report($sformatf("hit_slot got %0d want %0d", out_hit_slot, want.slot));
        if (out_entry_fraction !== want.frac)
          report($sformatf("entry_fraction got %0d want %0d",
                           out_entry_fraction, want.frac));
        if (out_hit === 1'b1) hits_seen++;
      end
    end
  end

  task automatic send_item(input logic cmd, input int slot, input logic alive,
                           input int px, py, pz, ex, ey, ez);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_slot <= SLOT_IN_W'(slot);
    in_alive <= alive;
    in_point_x <= coord_t'(px);
    in_point_y <= coord_t'(py);
    in_point_z <= coord_t'(pz);
    in_end_x <= coord_t'(ex);
    in_end_y <= coord_t'(ey);
    in_end_z <= coord_t'(ez);
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      slot_px[slot[4:0]] = coord_t'(px);
      slot_py[slot[4:0]] = coord_t'(py);
      slot_pz[slot[4:0]] = coord_t'(pz);
      slot_live[slot[4:0]] = alive;
    end else begin
      queries_sent++;
      expected_hits = {expected_hits,
                       nearest_hit(SLOT_IN_W'(slot), coord_t'(px), coord_t'(py),
                                   coord_t'(pz), coord_t'(ex), coord_t'(ey),
                                   coord_t'(ez))};
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_HALF_WIDTH) half_w = data;
    else if (idx == CFG_BOX_HEIGHT) height = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_item(CMD_QUERY, 31, 0, -1000, 100, 0, 1000, 100, 0);
    send_item(CMD_WRITE, 0, 1, 0, 0, 0, 0, 0, 0);
    send_item(CMD_WRITE, 1, 1, 0, 0, 0, 0, 0, 0);
    // equal boxes, lowest slot wins
    send_item(CMD_QUERY, 31, 0, -1000, 100, 0, 1000, 100, 0);
    // owner excluded
    send_item(CMD_QUERY, 0, 1, -1000, 100, 0, 1000, 100, 0);
    // flat x on the bound, then just outside
    send_item(CMD_QUERY, 31, 0, 102, -100, 0, 102, 600, 0);
    send_item(CMD_QUERY, 31, 0, 103, -100, 0, 103, 600, 0);
    // grazes a box edge, entry equals exit
    send_item(CMD_QUERY, 31, 0, 200, 363, 0, 0, 563, 0);
    // dead slot keeps position but is never hit
    send_item(CMD_WRITE, 2, 0, 500, 0, 0, 0, 0, 0);
    send_item(CMD_QUERY, 31, 0, 400, 100, 0, 600, 100, 0);
    // point query inside a box
    send_item(CMD_QUERY, 31, 0, 0, 100, 0, 0, 100, 0);
    send_item(CMD_WRITE, 31, 1, 8388607, -8388608, 8388607, -1, -1, -1);
    send_item(CMD_QUERY, 5, 1, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
    send_item(CMD_QUERY, 5, 0, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608);
    send_item(CMD_WRITE, 31, 0, -8388608, 8388607, -8388608, 0, 0, 0);
    send_item(CMD_QUERY, 30, 0, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_HALF_WIDTH, '0);
    write_reg(CFG_BOX_HEIGHT, '0);
    send_item(CMD_QUERY, 31, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_QUERY, 31, 0, -50, 0, 0, 50, 0, 0);
    send_item(CMD_QUERY, 31, 0, 1, 0, 0, 1, 5, 0);
    drain();
    write_reg(CFG_HALF_WIDTH, '1);
    write_reg(CFG_BOX_HEIGHT, '1);
    write_reg(CFG_UNUSED, 16'h0005);
    write_reg(CFG_UNUSED_HI, 16'h0007);
    send_item(CMD_QUERY, 31, 0, -70000, 70000, 70000, 70000, -70000, -70000);
    send_item(CMD_QUERY, 31, 0, 65535, 65535, -65535, 65535, 65535, -65535);
    drain();
  endtask

  function automatic int rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) return int'($urandom_range(4096)) - 2048;
    if (pick < 95) return int'(coord_t'($urandom));
    return pick[0] ? 8388607 : -8388608;
  endfunction

  task automatic random_items(input int count);
    int tgt, px, py, pz, ex, ey, ez;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 40) begin
        send_item(CMD_WRITE, $urandom_range(31), $urandom_range(99) < 50,
                  rand_coord(), rand_coord(), rand_coord(),
                  int'(coord_t'($urandom)), int'(coord_t'($urandom)),
                  int'(coord_t'($urandom)));
      end else begin
        px = rand_coord(); py = rand_coord(); pz = rand_coord();
        tgt = $urandom_range(31);
        if ($urandom_range(99) < 70) begin
          // aim at a slot to get hits
          ex = int'(slot_px[tgt]) + int'($urandom_range(400)) - 200;
          ey = int'(slot_py[tgt]) + int'($urandom_range(600)) - 100;
          ez = int'(slot_pz[tgt]) + int'($urandom_range(400)) - 200;
        end else begin
          ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
        end
        if ($urandom_range(99) < 15) ex = px;
        if ($urandom_range(99) < 15) ey = py;
        if ($urandom_range(99) < 15) ez = pz;
        send_item(CMD_QUERY, $urandom_range(31), $urandom_range(1), px, py, pz, ex, ey, ez);
      end
    end
  endtask

  task automatic test_random_phases();
    write_reg(CFG_HALF_WIDTH, 16'd102);
    write_reg(CFG_BOX_HEIGHT, 16'd461);
    idle_pct = 0;
    random_items(400);
    // hold off until the table is quiet
    drain();
    idle_pct = 81;
    random_items(350);
    drain();
    write_reg(CFG_HALF_WIDTH, 16'(300 + $urandom_range(2000)));
    write_reg(CFG_BOX_HEIGHT, 16'($urandom_range(4000)));
    idle_pct = 17;
    random_items(400);
    drain();
    write_reg(CFG_HALF_WIDTH, 16'd1);
    write_reg(CFG_BOX_HEIGHT, 16'd40000);
    idle_pct = 0;
    random_items(300);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_WRITE;
    in_slot = '0;
    in_alive = 1'b0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    in_end_x = '0; in_end_y = '0; in_end_z = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HALF_WIDTH;
    cfg_data = '0;
    errors = 0; cycles = 0; items_sent = 0; queries_sent = 0;
    hits_seen = 0; results_seen = 0; idle_pct = 0;
    half_w = CFG_W'(HW_RESET);
    height = CFG_W'(HT_RESET);
    for (int i = 0; i < SLOTS; i++) begin
      slot_px[i] = '0; slot_py[i] = '0; slot_pz[i] = '0;
      slot_live[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_phases();
    repeat (40) @(posedge clk);
    $display("covered %0d items, %0d queries, %0d results, %0d hits", items_sent,
             queries_sent, results_seen, hits_seen);
    $display("sender gaps 0/81/17 percent, register extremes, flat axes and ties");
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_hits.size() != 0) report("queries left without a result");
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
